// File: rtl/core/tba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tba_pkg
// Types, codes and defaults shared by the tiered block allocator.
// ----------------------------------------------------------------------------
package tba_pkg;

    localparam int ID_W            = 9;
    localparam int HOT_BLOCKS_DEF  = 64;
    localparam int WARM_BLOCKS_DEF = 192;

    localparam logic [2:0] REQ_ALLOC    = 3'd0;
    localparam logic [2:0] REQ_FREE     = 3'd1;
    localparam logic [2:0] REQ_LOCK     = 3'd2;
    localparam logic [2:0] REQ_UNLOCK   = 3'd3;
    localparam logic [2:0] REQ_MIGRATE  = 3'd4;
    localparam logic [2:0] REQ_SET_HEAT = 3'd5;

    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_OOM     = 3'd1;
    localparam logic [2:0] STS_UNKNOWN = 3'd2;
    localparam logic [2:0] STS_WRONG   = 3'd3;
    localparam logic [2:0] STS_FULL    = 3'd4;

    localparam logic [1:0] TIER_HOT  = 2'd0;
    localparam logic [1:0] TIER_WARM = 2'd1;
    localparam logic [1:0] TIER_COLD = 2'd2;
    localparam logic [1:0] TIER_SEL3 = 2'd3;

    localparam logic [1:0] BS_FREE  = 2'd0;
    localparam logic [1:0] BS_ALLOC = 2'd1;
    localparam logic [1:0] BS_LOCK  = 2'd2;

    typedef struct packed {
        logic [2:0]      req_type;
        logic [ID_W-1:0] block_ref;
        logic [1:0]      tier_sel;
        logic [7:0]      layer;
        logic [7:0]      head;
        logic [15:0]     heat_value;
    } req_t;

    typedef struct packed {
        logic            ok;
        logic [2:0]      status;
        logic [ID_W-1:0] result_block;
        logic [1:0]      result_tier;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        listed;
        logic [7:0]  layer;
        logic [7:0]  head;
        logic [15:0] heat;
    } meta_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_ALLOC_WR,
        S_RMW,
        S_SCAN,
        S_EVICT,
        S_MIG_WR
    } state_t;

endpackage

// File: rtl/core/tba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tba_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/tiered_block_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiered_block_allocator_unit
// Block allocator over a hot and a warm tier with coldest-block eviction.
// ----------------------------------------------------------------------------
// One request beat on req gives exactly one response beat on rsp. Both use
// valid/stall; a beat moves when valid is high and stall is low.
// One request is worked at a time: req_stall stays high from acceptance
// until the response has been taken by the receiver, so a stalled rsp
// holds off further requests.
// Path from acceptance to response: free, lock, unlock and set_heat pass
// S_EXEC then S_RMW, a migrate that moves a block adds S_MIG_WR, plain alloc
// passes S_EXEC then S_ALLOC_WR, and errors on decode are answered from S_EXEC.
// The next request is accepted at the earliest in the cycle after the response beat moves.
// An alloc that must evict scans the hot block metadata one entry per cycle
// through the single metadata RAM read port.
// After reset the block runs an init pass that clears the metadata RAM and
// fills both free lists; requests are stalled during that pass.
// ----------------------------------------------------------------------------
module tiered_block_allocator_unit
    import tba_pkg::*;
#(
    parameter int HOT_BLOCKS  = HOT_BLOCKS_DEF,
    parameter int WARM_BLOCKS = WARM_BLOCKS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int NBLK  = HOT_BLOCKS + WARM_BLOCKS;
    localparam int MA_W  = $clog2(NBLK + 1);
    localparam int HA_W  = (HOT_BLOCKS > 1) ? $clog2(HOT_BLOCKS) : 1;
    localparam int WA_W  = (WARM_BLOCKS > 1) ? $clog2(WARM_BLOCKS) : 1;
    localparam int HC_W  = $clog2(HOT_BLOCKS + 1);
    localparam int WC_W  = $clog2(WARM_BLOCKS + 1);
    localparam int HS_W  = HC_W + 1;
    localparam int WS_W  = WC_W + 1;
    localparam int MT_W  = $bits(meta_t);

    state_t state_reg, state_next;
    logic [MA_W-1:0] ci_reg, ci_next;
    req_t            req_q_reg;
    req_t            req_in;
    logic [HA_W-1:0] hot_rd_reg, hot_rd_next;
    logic [HC_W-1:0] hot_cnt_reg, hot_cnt_next;
    logic [WA_W-1:0] warm_rd_reg, warm_rd_next;
    logic [WC_W-1:0] warm_cnt_reg, warm_cnt_next;
    meta_t           src_reg, src_next;
    logic [ID_W-1:0] dst_reg, dst_next;
    logic [ID_W-1:0] best_id_reg, best_id_next;
    meta_t           best_meta_reg, best_meta_next;
    logic            best_found_reg, best_found_next;
    logic            cmp_valid_reg, cmp_valid_next;
    logic [MA_W-1:0] cmp_id_reg, cmp_id_next;
    logic [ID_W-1:0] res_blk_reg, res_blk_next;
    logic [1:0]      res_tier_reg, res_tier_next;
    logic            rsp_valid_reg;
    rsp_t            rsp_reg;

    logic            meta_we;
    logic [MA_W-1:0] meta_waddr, meta_raddr;
    meta_t           meta_wdata, meta_rdata;
    logic [MT_W-1:0] meta_rdata_raw;

    logic            hot_push, hot_pop, hot_push_ok, hot_we;
    logic [ID_W-1:0] hot_pdata, hot_wdata, hot_rdata;
    logic [HA_W-1:0] hot_waddr, hot_paddr;
    logic [HS_W-1:0] hot_sum;
    logic            warm_push, warm_pop, warm_push_ok, warm_we;
    logic [ID_W-1:0] warm_pdata, warm_wdata, warm_rdata;
    logic [WA_W-1:0] warm_waddr, warm_paddr;
    logic [WS_W-1:0] warm_sum;

    logic            init_we, init_hot, init_warm;
    logic            rsp_load;
    logic [2:0]      rsp_status;
    logic [ID_W-1:0] rsp_blk;
    logic [1:0]      rsp_tier;
    logic            accept;
    logic            ref_ok;
    logic [1:0]      ref_tier;
    logic [1:0]      tsel;
    logic [MA_W-1:0] ref_addr;
    logic            cand, better;

    // ------------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------------
    tba_ram #(.WIDTH(MT_W), .DEPTH(NBLK + 1), .AW(MA_W)) u_meta (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata_raw)
    );
    assign meta_rdata = meta_t'(meta_rdata_raw);

    tba_ram #(.WIDTH(ID_W), .DEPTH(HOT_BLOCKS), .AW(HA_W)) u_hot_fifo (
        .clk   (clk),
        .we    (hot_we),
        .waddr (hot_waddr),
        .wdata (hot_wdata),
        .raddr (hot_rd_reg),
        .rdata (hot_rdata)
    );

    tba_ram #(.WIDTH(ID_W), .DEPTH(WARM_BLOCKS), .AW(WA_W)) u_warm_fifo (
        .clk   (clk),
        .we    (warm_we),
        .waddr (warm_waddr),
        .wdata (warm_wdata),
        .raddr (warm_rd_reg),
        .rdata (warm_rdata)
    );

    // ------------------------------------------------------------------------
    // Decode helpers
    // ------------------------------------------------------------------------
    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE) || rsp_valid_reg;
    assign tsel      = req_q_reg.tier_sel;
    assign ref_ok    = (req_q_reg.block_ref != '0) && (32'(req_q_reg.block_ref) <= NBLK);
    assign ref_tier  = (32'(req_q_reg.block_ref) <= HOT_BLOCKS) ? TIER_HOT : TIER_WARM;
    assign ref_addr  = MA_W'(req_q_reg.block_ref);

    // tier selector three behaves as cold
    always_comb
    begin
        req_in = req;
        if (req.tier_sel == TIER_SEL3)
        begin
            req_in.tier_sel = TIER_COLD;
        end
    end

    assign cand   = meta_rdata.listed && (meta_rdata.status == BS_ALLOC);
    assign better = !best_found_reg || (meta_rdata.heat < best_meta_reg.heat);

    // free list write side
    assign hot_push_ok  = hot_push && (hot_cnt_reg != HC_W'(HOT_BLOCKS));
    assign warm_push_ok = warm_push && (warm_cnt_reg != WC_W'(WARM_BLOCKS));
    assign hot_sum      = HS_W'(hot_rd_reg) + HS_W'(hot_cnt_reg);
    assign warm_sum     = WS_W'(warm_rd_reg) + WS_W'(warm_cnt_reg);
    assign hot_paddr    = (hot_sum >= HS_W'(HOT_BLOCKS)) ?
                          HA_W'(hot_sum - HS_W'(HOT_BLOCKS)) : HA_W'(hot_sum);
    assign warm_paddr   = (warm_sum >= WS_W'(WARM_BLOCKS)) ?
                          WA_W'(warm_sum - WS_W'(WARM_BLOCKS)) : WA_W'(warm_sum);

    assign init_hot  = init_we && (ci_reg != '0) && (32'(ci_reg) <= HOT_BLOCKS);
    assign init_warm = init_we && (32'(ci_reg) > HOT_BLOCKS);

    assign hot_we     = init_hot || hot_push_ok;
    assign hot_waddr  = init_hot ? HA_W'(ci_reg - MA_W'(1)) : hot_paddr;
    assign hot_wdata  = init_hot ? ID_W'(ci_reg) : hot_pdata;
    assign warm_we    = init_warm || warm_push_ok;
    assign warm_waddr = init_warm ? WA_W'(ci_reg - MA_W'(HOT_BLOCKS + 1)) : warm_paddr;
    assign warm_wdata = init_warm ? ID_W'(ci_reg) : warm_pdata;

    always_comb
    begin
        hot_rd_next  = hot_rd_reg;
        warm_rd_next = warm_rd_reg;
        if (hot_pop)
        begin
            hot_rd_next = (hot_rd_reg == HA_W'(HOT_BLOCKS - 1)) ? '0 : hot_rd_reg + 1'b1;
        end
        if (warm_pop)
        begin
            warm_rd_next = (warm_rd_reg == WA_W'(WARM_BLOCKS - 1)) ? '0 : warm_rd_reg + 1'b1;
        end
        hot_cnt_next  = hot_cnt_reg + HC_W'(hot_push_ok) - HC_W'(hot_pop);
        warm_cnt_next = warm_cnt_reg + WC_W'(warm_push_ok) - WC_W'(warm_pop);
    end

    // ------------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            ci_reg         <= '0;
            hot_rd_reg     <= '0;
            hot_cnt_reg    <= HC_W'(HOT_BLOCKS);
            warm_rd_reg    <= '0;
            warm_cnt_reg   <= WC_W'(WARM_BLOCKS);
            best_found_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ci_reg         <= ci_next;
            hot_rd_reg     <= hot_rd_next;
            hot_cnt_reg    <= hot_cnt_next;
            warm_rd_reg    <= warm_rd_next;
            warm_cnt_reg   <= warm_cnt_next;
            best_found_reg <= best_found_next;
            cmp_valid_reg  <= cmp_valid_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_q_reg <= req_in;
        end
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        best_id_reg   <= best_id_next;
        best_meta_reg <= best_meta_next;
        cmp_id_reg    <= cmp_id_next;
        res_blk_reg   <= res_blk_next;
        res_tier_reg  <= res_tier_next;
        if (rsp_load)
        begin
            rsp_reg.ok           <= (rsp_status == STS_OK);
            rsp_reg.status       <= rsp_status;
            rsp_reg.result_block <= rsp_blk;
            rsp_reg.result_tier  <= rsp_tier;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ci_next         = ci_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        best_id_next    = best_id_reg;
        best_meta_next  = best_meta_reg;
        best_found_next = best_found_reg;
        cmp_valid_next  = 1'b0;
        cmp_id_next     = cmp_id_reg;
        res_blk_next    = res_blk_reg;
        res_tier_next   = res_tier_reg;
        meta_we         = 1'b0;
        meta_waddr      = '0;
        meta_wdata      = '0;
        meta_raddr      = '0;
        hot_push        = 1'b0;
        hot_pop         = 1'b0;
        hot_pdata       = '0;
        warm_push       = 1'b0;
        warm_pop        = 1'b0;
        warm_pdata      = '0;
        init_we         = 1'b0;
        rsp_load        = 1'b0;
        rsp_status      = STS_OK;
        rsp_blk         = '0;
        rsp_tier        = TIER_HOT;

        unique case (state_reg)
            S_INIT:
            begin
                init_we    = 1'b1;
                meta_we    = 1'b1;
                meta_waddr = ci_reg;
                ci_next    = ci_reg + 1'b1;
                if (ci_reg == MA_W'(NBLK))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (req_q_reg.req_type == REQ_ALLOC)
                begin
                    if (tsel == TIER_WARM && warm_cnt_reg != '0)
                    begin
                        warm_pop      = 1'b1;
                        dst_next      = warm_rdata;
                        res_tier_next = TIER_WARM;
                        meta_raddr    = MA_W'(warm_rdata);
                        state_next    = S_ALLOC_WR;
                    end
                    else if (hot_cnt_reg != '0)
                    begin
                        hot_pop       = 1'b1;
                        dst_next      = hot_rdata;
                        res_tier_next = TIER_HOT;
                        meta_raddr    = MA_W'(hot_rdata);
                        state_next    = S_ALLOC_WR;
                    end
                    else if (tsel == TIER_HOT && warm_cnt_reg != '0)
                    begin
                        // only a hot eviction into warm can succeed
                        ci_next         = MA_W'(1);
                        best_found_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        rsp_load   = 1'b1;
                        rsp_status = STS_OOM;
                        state_next = S_IDLE;
                    end
                end
                else if (req_q_reg.req_type > REQ_SET_HEAT)
                begin
                    rsp_load   = 1'b1;
                    rsp_status = STS_WRONG;
                    state_next = S_IDLE;
                end
                else if (!ref_ok)
                begin
                    rsp_load   = 1'b1;
                    rsp_status = STS_UNKNOWN;
                    state_next = S_IDLE;
                end
                else
                begin
                    meta_raddr = ref_addr;
                    state_next = S_RMW;
                end
            end

            S_ALLOC_WR:
            begin
                meta_we           = 1'b1;
                meta_waddr        = MA_W'(dst_reg);
                meta_wdata.status = BS_ALLOC;
                meta_wdata.listed = 1'b1;
                meta_wdata.layer  = req_q_reg.layer;
                meta_wdata.head   = req_q_reg.head;
                meta_wdata.heat   = meta_rdata.heat;
                rsp_load          = 1'b1;
                rsp_blk           = dst_reg;
                rsp_tier          = res_tier_reg;
                state_next        = S_IDLE;
            end

            S_RMW:
            begin
                meta_waddr = ref_addr;
                meta_wdata = meta_rdata;
                rsp_load   = 1'b1;
                state_next = S_IDLE;
                case (req_q_reg.req_type)
                    REQ_FREE:
                    begin
                        if (meta_rdata.status != BS_ALLOC)
                        begin
                            rsp_status = STS_WRONG;
                        end
                        else
                        begin
                            meta_we           = 1'b1;
                            meta_wdata.status = BS_FREE;
                            meta_wdata.listed = 1'b0;
                            meta_wdata.layer  = '0;
                            meta_wdata.head   = '0;
                            if (ref_tier == TIER_HOT)
                            begin
                                hot_push  = 1'b1;
                                hot_pdata = req_q_reg.block_ref;
                            end
                            else
                            begin
                                warm_push  = 1'b1;
                                warm_pdata = req_q_reg.block_ref;
                            end
                        end
                    end
                    REQ_LOCK:
                    begin
                        if (meta_rdata.status == BS_FREE)
                        begin
                            rsp_status = STS_WRONG;
                        end
                        else
                        begin
                            meta_we           = 1'b1;
                            meta_wdata.status = BS_LOCK;
                        end
                    end
                    REQ_UNLOCK:
                    begin
                        if (meta_rdata.status != BS_LOCK)
                        begin
                            rsp_status = STS_WRONG;
                        end
                        else
                        begin
                            meta_we           = 1'b1;
                            meta_wdata.status = BS_ALLOC;
                        end
                    end
                    REQ_SET_HEAT:
                    begin
                        meta_we         = 1'b1;
                        meta_wdata.heat = req_q_reg.heat_value;
                    end
                    REQ_MIGRATE:
                    begin
                        if (meta_rdata.status == BS_FREE)
                        begin
                            rsp_status = STS_WRONG;
                        end
                        else if (ref_tier == tsel)
                        begin
                            rsp_status = STS_OK;
                        end
                        else if ((tsel == TIER_WARM && warm_cnt_reg != '0) ||
                                 (tsel == TIER_HOT && hot_cnt_reg != '0))
                        begin
                            rsp_load          = 1'b0;
                            src_next          = meta_rdata;
                            res_blk_next      = '0;
                            res_tier_next     = TIER_HOT;
                            meta_we           = 1'b1;
                            meta_wdata.status = BS_FREE;
                            meta_wdata.listed = 1'b0;
                            if (tsel == TIER_WARM)
                            begin
                                warm_pop   = 1'b1;
                                dst_next   = warm_rdata;
                                meta_raddr = MA_W'(warm_rdata);
                                hot_push   = 1'b1;
                                hot_pdata  = req_q_reg.block_ref;
                            end
                            else
                            begin
                                hot_pop    = 1'b1;
                                dst_next   = hot_rdata;
                                meta_raddr = MA_W'(hot_rdata);
                                warm_push  = 1'b1;
                                warm_pdata = req_q_reg.block_ref;
                            end
                            state_next = S_MIG_WR;
                        end
                        else
                        begin
                            rsp_status = STS_FULL;
                        end
                    end
                    default:
                    begin
                        rsp_status = STS_WRONG;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (cmp_valid_reg && cand && better)
                begin
                    best_found_next = 1'b1;
                    best_id_next    = ID_W'(cmp_id_reg);
                    best_meta_next  = meta_rdata;
                end
                if (32'(ci_reg) <= HOT_BLOCKS)
                begin
                    meta_raddr     = ci_reg;
                    cmp_valid_next = 1'b1;
                    cmp_id_next    = ci_reg;
                    ci_next        = ci_reg + 1'b1;
                end
                else if (!cmp_valid_reg)
                begin
                    state_next = S_EVICT;
                end
            end

            S_EVICT:
            begin
                if (!best_found_reg)
                begin
                    rsp_load   = 1'b1;
                    rsp_status = STS_OOM;
                    state_next = S_IDLE;
                end
                else
                begin
                    // victim moves to warm, its id returns to hot and is re-granted
                    warm_pop          = 1'b1;
                    dst_next          = warm_rdata;
                    meta_raddr        = MA_W'(warm_rdata);
                    hot_push          = 1'b1;
                    hot_pdata         = best_id_reg;
                    hot_pop           = 1'b1;
                    meta_we           = 1'b1;
                    meta_waddr        = MA_W'(best_id_reg);
                    meta_wdata.status = BS_ALLOC;
                    meta_wdata.listed = 1'b1;
                    meta_wdata.layer  = req_q_reg.layer;
                    meta_wdata.head   = req_q_reg.head;
                    meta_wdata.heat   = best_meta_reg.heat;
                    src_next          = best_meta_reg;
                    res_blk_next      = best_id_reg;
                    res_tier_next     = TIER_HOT;
                    state_next        = S_MIG_WR;
                end
            end

            S_MIG_WR:
            begin
                meta_we           = 1'b1;
                meta_waddr        = MA_W'(dst_reg);
                meta_wdata.status = src_reg.status;
                meta_wdata.listed = meta_rdata.listed;
                meta_wdata.layer  = src_reg.layer;
                meta_wdata.head   = src_reg.head;
                meta_wdata.heat   = meta_rdata.heat;
                rsp_load          = 1'b1;
                rsp_blk           = res_blk_reg;
                rsp_tier          = res_tier_reg;
                state_next        = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: tb/sv/tiered_block_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiered_block_allocator_unit_tb
// Drives alloc, free, lock, unlock, migrate and set_heat requests through the
// allocator with random bursts and response stalls, and checks every
// response against a behavioral model of the free lists and block metadata.
// ----------------------------------------------------------------------------
module tiered_block_allocator_unit_tb;
    import tba_pkg::*;

    localparam int NBLK = HOT_BLOCKS_DEF + WARM_BLOCKS_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    class alloc_scoreboard;
        logic [8:0]  hot_q[$];
        logic [8:0]  warm_q[$];
        logic [1:0]  tier_of[NBLK+1];
        logic [1:0]  bstate[NBLK+1];
        bit          listed[NBLK+1];
        logic [7:0]  blayer[NBLK+1];
        logic [7:0]  bhead[NBLK+1];
        logic [15:0] bheat[NBLK+1];
        rsp_t        pending[$];
        int          errors;

        function new();
            hot_q.delete();
            warm_q.delete();
            for (int i = 1; i <= NBLK; i++)
            begin
                tier_of[i] = (i <= HOT_BLOCKS_DEF) ? TIER_HOT : TIER_WARM;
                bstate[i] = BS_FREE;
                listed[i] = 0;
                blayer[i] = '0;
                bhead[i] = '0;
                bheat[i] = '0;
                if (i <= HOT_BLOCKS_DEF) hot_q = {hot_q, i[8:0]};
                else warm_q = {warm_q, i[8:0]};
            end
            errors = 0;
        endfunction

        function int free_count(logic [1:0] t);
            if (t == TIER_HOT) return hot_q.size();
            if (t == TIER_WARM) return warm_q.size();
            return 0;
        endfunction

        function logic [8:0] pop_tier(logic [1:0] t);
            if (t == TIER_HOT && hot_q.size() > 0) return hot_q.pop_front();
            if (t == TIER_WARM && warm_q.size() > 0) return warm_q.pop_front();
            return '0;
        endfunction

        function void push_tier(logic [1:0] t, logic [8:0] id);
            if (t == TIER_HOT) hot_q = {hot_q, id};
            else if (t == TIER_WARM) warm_q = {warm_q, id};
        endfunction

        function logic [8:0] grant(logic [1:0] t, logic [7:0] ly, logic [7:0] hd);
            logic [8:0] id;
            id = pop_tier(t);
            if (id != 0)
            begin
                bstate[id] = BS_ALLOC;
                blayer[id] = ly;
                bhead[id] = hd;
                listed[id] = 1;
            end
            return id;
        endfunction

        function logic [2:0] move_block(logic [8:0] id, logic [1:0] tgt);
            logic [8:0] dst;
            if (bstate[id] == BS_FREE) return STS_WRONG;
            if (tier_of[id] == tgt) return STS_OK;
            if (free_count(tgt) == 0) return STS_FULL;
            dst = pop_tier(tgt);
            blayer[dst] = blayer[id];
            bhead[dst] = bhead[id];
            bstate[dst] = bstate[id];
            bstate[id] = BS_FREE;
            listed[id] = 0;
            push_tier(tier_of[id], id);
            return STS_OK;
        endfunction

        function void note_request(req_t r);
            rsp_t       e;
            logic [1:0] ts;
            logic [8:0] blk;
            logic [8:0] best;
            logic [2:0] st;
            bit         ok_id;
            ts = (r.tier_sel == TIER_SEL3) ? TIER_COLD : r.tier_sel;
            st = STS_OK;
            blk = '0;
            ok_id = (r.block_ref >= 1 && r.block_ref <= NBLK);
            if (r.req_type == REQ_ALLOC)
            begin
                blk = grant(ts, r.layer, r.head);
                if (blk == 0 && ts != TIER_HOT) blk = grant(TIER_HOT, r.layer, r.head);
                if (blk == 0)
                begin
                    best = '0;
                    for (int i = 1; i <= NBLK; i++)
                        if (listed[i] && bstate[i] == BS_ALLOC && tier_of[i] == ts &&
                            (best == 0 || bheat[i] < bheat[best]))
                            best = i[8:0];
                    if (best != 0)
                        if (move_block(best, (tier_of[best] == TIER_HOT) ? TIER_WARM
                                                                        : TIER_COLD) == STS_OK)
                            blk = grant(ts, r.layer, r.head);
                end
                if (blk == 0) st = STS_OOM;
            end
            else if (r.req_type > REQ_SET_HEAT) st = STS_WRONG;
            else if (!ok_id) st = STS_UNKNOWN;
            else if (r.req_type == REQ_FREE)
            begin
                if (bstate[r.block_ref] != BS_ALLOC) st = STS_WRONG;
                else
                begin
                    bstate[r.block_ref] = BS_FREE;
                    listed[r.block_ref] = 0;
                    blayer[r.block_ref] = '0;
                    bhead[r.block_ref] = '0;
                    push_tier(tier_of[r.block_ref], r.block_ref);
                end
            end
            else if (r.req_type == REQ_LOCK)
            begin
                if (bstate[r.block_ref] == BS_FREE) st = STS_WRONG;
                else bstate[r.block_ref] = BS_LOCK;
            end
            else if (r.req_type == REQ_UNLOCK)
            begin
                if (bstate[r.block_ref] != BS_LOCK) st = STS_WRONG;
                else bstate[r.block_ref] = BS_ALLOC;
            end
            else if (r.req_type == REQ_MIGRATE) st = move_block(r.block_ref, ts);
            else bheat[r.block_ref] = r.heat_value;
            e.ok = (st == STS_OK);
            e.status = st;
            e.result_block = blk;
            e.result_tier = (blk != 0) ? tier_of[blk] : TIER_HOT;
            pending = {pending, e};
        endfunction

        function void check_response(rsp_t a);
            rsp_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected response %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.ok !== e.ok || a.status !== e.status ||
                a.result_block !== e.result_block || a.result_tier !== e.result_tier)
            begin
                $display("%0t: response mismatch expected ok=%0d st=%0d blk=%0d tier=%0d",
                         $time, e.ok, e.status, e.result_block, e.result_tier);
                $display("%0t:                   actual   ok=%0d st=%0d blk=%0d tier=%0d",
                         $time, a.ok, a.status, a.result_block, a.result_tier);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    alloc_scoreboard sb;
    int  cycles;
    bit  long_hold;

    tiered_block_allocator_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall) sb.note_request(req);
            if (rsp_valid && !rsp_stall) sb.check_response(rsp);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tiered_block_allocator_unit_tb NOT OK");
            $finish;
        end
    end

    // receiver: own stall pattern plus one long hold-off
    initial
    begin
        int mode;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp_stall <= 1'b1;
                repeat (300) @(negedge clk);
                long_hold = 0;
            end
            mode = (cycles / 400) % 3;
            if (mode == 0) rsp_stall <= 1'b0;
            else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
            else rsp_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    task automatic send_beat(req_t r);
        req <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    task automatic idle_gap(int n);
        req_valid <= 1'b0;
        req <= '0;
        repeat (n) @(negedge clk);
    endtask

    function automatic req_t make_req(logic [2:0] t, logic [8:0] id, logic [1:0] ts);
        req_t r;
        r.req_type = t;
        r.block_ref = id;
        r.tier_sel = ts;
        r.layer = 8'($urandom);
        r.head = 8'($urandom);
        r.heat_value = 16'($urandom);
        return r;
    endfunction

    function automatic logic [8:0] pick_id();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return 9'd0;
        if (k == 1) return 9'($urandom_range(NBLK + 1, 511));
        if (k == 2) return 9'(NBLK);
        if (k < 10) return 9'($urandom_range(1, 24));
        return 9'($urandom_range(1, NBLK));
    endfunction

    function automatic req_t rand_req();
        int k;
        k = $urandom_range(0, 99);
        if (k < 35) return make_req(REQ_ALLOC, 9'($urandom), 2'($urandom_range(0, 3)));
        if (k < 50) return make_req(REQ_FREE, pick_id(), 2'($urandom));
        if (k < 60) return make_req(REQ_LOCK, pick_id(), 2'($urandom));
        if (k < 68) return make_req(REQ_UNLOCK, pick_id(), 2'($urandom));
        if (k < 80) return make_req(REQ_MIGRATE, pick_id(), 2'($urandom_range(0, 3)));
        if (k < 97) return make_req(REQ_SET_HEAT, pick_id(), 2'($urandom));
        return make_req(3'($urandom_range(6, 7)), 9'($urandom), 2'($urandom));
    endfunction

    initial
    begin
        req_t r;
        int   burst;
        sb = new();
        cycles = 0;
        long_hold = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        r = make_req(REQ_ALLOC, 9'd0, TIER_HOT);
        r.layer = 8'hFF; r.head = 8'h00;
        send_beat(r);
        r = make_req(REQ_ALLOC, 9'd0, TIER_WARM); r.layer = 8'h00; r.head = 8'hFF;
        send_beat(r);
        send_beat(make_req(REQ_ALLOC, 9'd0, TIER_COLD));
        send_beat(make_req(REQ_ALLOC, 9'h1FF, TIER_SEL3));
        send_beat(make_req(REQ_FREE, 9'd0, TIER_HOT));
        send_beat(make_req(REQ_FREE, 9'd257, TIER_HOT));
        send_beat(make_req(REQ_FREE, 9'h1FF, TIER_HOT));
        send_beat(make_req(REQ_FREE, 9'd100, TIER_HOT));
        send_beat(make_req(REQ_LOCK, 9'd100, TIER_HOT));
        send_beat(make_req(REQ_UNLOCK, 9'd1, TIER_HOT));
        send_beat(make_req(REQ_LOCK, 9'd1, TIER_HOT));
        send_beat(make_req(REQ_LOCK, 9'd1, TIER_HOT));
        send_beat(make_req(REQ_FREE, 9'd1, TIER_HOT));
        send_beat(make_req(REQ_UNLOCK, 9'd1, TIER_HOT));
        send_beat(make_req(REQ_MIGRATE, 9'd200, TIER_HOT));
        send_beat(make_req(REQ_MIGRATE, 9'd2, TIER_HOT));
        send_beat(make_req(REQ_MIGRATE, 9'd2, TIER_COLD));
        send_beat(make_req(REQ_MIGRATE, 9'd2, TIER_SEL3));
        send_beat(make_req(REQ_MIGRATE, 9'd2, TIER_WARM));
        r = make_req(REQ_SET_HEAT, 9'd256, TIER_HOT); r.heat_value = 16'hFFFF;
        send_beat(r);
        r = make_req(REQ_SET_HEAT, 9'd3, TIER_HOT); r.heat_value = 16'h0000;
        send_beat(r);
        send_beat(make_req(3'd6, 9'd1, TIER_HOT));
        send_beat(make_req(3'd7, 9'd1, TIER_HOT));

        // fill hot and evict, then set heat on the hot blocks; hold the receiver meanwhile
        long_hold = 1;
        for (int i = 0; i < 80; i++)
            send_beat(make_req(REQ_ALLOC, 9'd0, TIER_HOT));
        for (int i = 1; i <= 64; i++)
        begin
            r = make_req(REQ_SET_HEAT, i[8:0], TIER_HOT);
            r.heat_value = 16'($urandom_range(0, 3));
            send_beat(r);
        end

        // pause until drained
        idle_gap(1);
        while (sb.pending.size() != 0) @(negedge clk);

        for (int n = 0; n < 650; n += burst)
        begin
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst; j++)
                send_beat(rand_req());
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
        end
        idle_gap(1);
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tiered_block_allocator_unit_tb OK");
        else
            $display("tiered_block_allocator_unit_tb NOT OK");
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/tba_pkg.sv
rtl/core/tba_ram.sv
rtl/core/tiered_block_allocator_unit.sv
tb/sv/tiered_block_allocator_unit_tb.sv
